[design/pps_pkg.sv]
// Package for the preemptive priority scheduler.
// Holds the widths, table size, record codes and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package pps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  localparam int ARR_W  = 16;
  localparam int BST_W  = 12;
  localparam int PRI_W  = 8;
  localparam int TIME_W = 17;
  localparam int TASK_W = 5;

  localparam logic REC_SWITCH = 1'b0;
  localparam logic REC_DONE   = 1'b1;

  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BST_W-1:0] burst;
    logic [BST_W-1:0] remain;
    logic [PRI_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  pick_idx;
    logic [ARR_W-1:0]  pick_arr;
    logic [BST_W-1:0]  pick_bst;
    logic [BST_W-1:0]  pick_rem;
    logic [PRI_W-1:0]  pick_pri;
    logic              next_found;
    logic [ARR_W-1:0]  next_arr;
  } scan_res_t;

  typedef struct packed {
    logic              kind;
    logic [TASK_W-1:0] task_num;
    logic [TIME_W-1:0] ct;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic              fin;
  } rec_t;

endpackage

[design/pps_scan.sv]
// Shared scheduler compare unit: takes one table entry per cycle while en is
// high and keeps the most urgent ready task and the earliest future arrival.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_scan (
  input  logic                    clk,
  input  logic                    clear,
  input  logic                    en,
  input  logic [pps_pkg::IDX_W-1:0]  idx,
  input  pps_pkg::entry_t         ent,
  input  logic [pps_pkg::TIME_W-1:0] cur_time,
  output pps_pkg::scan_res_t      res
);

  logic                        found_r;
  logic [pps_pkg::IDX_W-1:0]   pick_idx_r;
  logic [pps_pkg::ARR_W-1:0]   pick_arr_r;
  logic [pps_pkg::BST_W-1:0]   pick_bst_r;
  logic [pps_pkg::BST_W-1:0]   pick_rem_r;
  logic [pps_pkg::PRI_W-1:0]   pick_pri_r;
  logic                        next_found_r;
  logic [pps_pkg::ARR_W-1:0]   next_arr_r;

  logic live;
  logic arrived;
  logic take_pick;
  logic take_next;

  assign live      = (ent.remain != '0);
  assign arrived   = ({1'b0, ent.arrival} <= cur_time);
  assign take_pick = live && arrived && (!found_r || (ent.prio < pick_pri_r));
  assign take_next = live && !arrived && (!next_found_r || (ent.arrival < next_arr_r));

  always_ff @(posedge clk) begin
    if (clear) begin
      found_r      <= 1'b0;
      next_found_r <= 1'b0;
    end else if (en) begin
      if (take_pick) begin
        found_r    <= 1'b1;
        pick_idx_r <= idx;
        pick_arr_r <= ent.arrival;
        pick_bst_r <= ent.burst;
        pick_rem_r <= ent.remain;
        pick_pri_r <= ent.prio;
      end
      if (take_next) begin
        next_found_r <= 1'b1;
        next_arr_r   <= ent.arrival;
      end
    end
  end

  always_comb begin
    res.found      = found_r;
    res.pick_idx   = pick_idx_r;
    res.pick_arr   = pick_arr_r;
    res.pick_bst   = pick_bst_r;
    res.pick_rem   = pick_rem_r;
    res.pick_pri   = pick_pri_r;
    res.next_found = next_found_r;
    res.next_arr   = next_arr_r;
  end

endmodule

[design/pps_outreg.sv]
// Output register of the scheduler: holds one record for the receiver.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_outreg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pps_pkg::rec_t rec_in,
  input  logic          out_stall,
  output logic          free,
  output logic          out_valid,
  output pps_pkg::rec_t rec_out
);

  logic          out_valid_r;
  pps_pkg::rec_t rec_r;

  assign free      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign rec_out   = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rec_r <= rec_in;
    end
  end

endmodule

[design/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler, top level.
// Task descriptors are transferred on the in_ channel, one per cycle while
// in_stall is low, into a table of up to 16 entries; a descriptor that
// arrives with the table full is dropped. The descriptor with in_last_task
// set starts the schedule run, and in_stall stays high until the run has
// placed its last record in the output register. The run works in passes:
// each pass reads the table one entry per cycle in S_ISSUE through a single
// compare unit and reaches its decision in S_DECIDE after S_DRAIN. A pass
// either jumps time to the next arrival or runs the chosen task up to its
// completion or the next arrival in one step, which adds a table update in
// S_UPDATE, a switch record in S_SWITCH when the chosen task differs from
// the previous one, and S_TAT and S_COMP to form and emit a completion record.
// At most 3N passes make up a run, a number independent of the burst lengths.
// Records leave through a one-entry output register; while out_stall is high
// the record holds and the sequencer waits before pushing another record.
// The completion record with out_final_record set ends the run and the block
// takes descriptors again. Reset empties the table and clears the run state;
// the table contents themselves are not cleared.
// Depends on pps_pkg, pps_scan and pps_outreg.
`timescale 1ns / 1ps

module preemptive_priority_scheduler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pps_pkg::ARR_W-1:0]    in_arrival_time,
  input  logic [pps_pkg::BST_W-1:0]    in_burst_time,
  input  logic [pps_pkg::PRI_W-1:0]    in_task_priority,
  input  logic                         in_last_task,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_record_kind,
  output logic [pps_pkg::TASK_W-1:0]   out_task_number,
  output logic [pps_pkg::TIME_W-1:0]   out_completion_time,
  output logic [pps_pkg::TIME_W-1:0]   out_turnaround_time,
  output logic [pps_pkg::TIME_W-1:0]   out_waiting_time,
  output logic                         out_final_record
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SWITCH = 3'd4;
  localparam logic [2:0] S_UPDATE = 3'd5;
  localparam logic [2:0] S_TAT    = 3'd6;
  localparam logic [2:0] S_COMP   = 3'd7;

  pps_pkg::entry_t mem [pps_pkg::MAX_PROCS];
  pps_pkg::entry_t rd_data_r;
  logic            rd_valid_r;
  logic [pps_pkg::IDX_W-1:0] rd_idx_r;

  logic [2:0]                  state_r, state_nxt;
  logic [pps_pkg::CNT_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic [pps_pkg::CNT_W-1:0]   done_cnt_r, done_cnt_nxt;
  logic [pps_pkg::CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [pps_pkg::TIME_W-1:0]  time_r, time_nxt;
  logic [pps_pkg::TASK_W-1:0]  prev_r, prev_nxt;
  logic [pps_pkg::BST_W-1:0]   run_r, run_nxt;
  logic [pps_pkg::TIME_W-1:0]  tat_r, tat_nxt;

  logic                        mem_we;
  logic [pps_pkg::IDX_W-1:0]   mem_wa;
  pps_pkg::entry_t             mem_wd;

  pps_pkg::scan_res_t          sres;
  logic                        scan_clr;
  logic                        in_xfer;
  logic                        full;
  logic [pps_pkg::BST_W-1:0]   burst_fix;
  logic [pps_pkg::TASK_W-1:0]  pick_task;
  logic [pps_pkg::TIME_W-1:0]  delta;
  logic [pps_pkg::BST_W-1:0]   rem_left;

  logic                        out_free;
  logic                        push;
  pps_pkg::rec_t               push_rec;
  pps_pkg::rec_t               out_rec;

  assign in_stall  = (state_r != S_LOAD);
  assign in_xfer   = in_valid && !in_stall;
  assign full      = (load_cnt_r == pps_pkg::CNT_W'(pps_pkg::MAX_PROCS));
  assign burst_fix = (in_burst_time == '0) ? pps_pkg::BST_W'(1) : in_burst_time;
  assign pick_task = pps_pkg::TASK_W'(sres.pick_idx) + pps_pkg::TASK_W'(1);
  assign delta     = {1'b0, sres.next_arr} - time_r;
  assign rem_left  = sres.pick_rem - run_r;
  assign scan_clr  = (state_r == S_ISSUE) && (scan_idx_r == '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[scan_idx_r[pps_pkg::IDX_W-1:0]];
    rd_idx_r  <= scan_idx_r[pps_pkg::IDX_W-1:0];
  end

  pps_scan u_scan (
    .clk      (clk),
    .clear    (scan_clr),
    .en       (rd_valid_r),
    .idx      (rd_idx_r),
    .ent      (rd_data_r),
    .cur_time (time_r),
    .res      (sres)
  );

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    done_cnt_nxt = done_cnt_r;
    scan_idx_nxt = scan_idx_r;
    time_nxt     = time_r;
    prev_nxt     = prev_r;
    run_nxt      = run_r;
    tat_nxt      = tat_r;
    mem_we       = 1'b0;
    mem_wa       = load_cnt_r[pps_pkg::IDX_W-1:0];
    mem_wd.arrival = in_arrival_time;
    mem_wd.burst   = burst_fix;
    mem_wd.remain  = burst_fix;
    mem_wd.prio    = in_task_priority;
    push          = 1'b0;
    push_rec.kind     = pps_pkg::REC_SWITCH;
    push_rec.task_num = pick_task;
    push_rec.ct       = '0;
    push_rec.tat      = '0;
    push_rec.wt       = '0;
    push_rec.fin      = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (!full) begin
            mem_we       = 1'b1;
            load_cnt_nxt = load_cnt_r + pps_pkg::CNT_W'(1);
          end
          if (in_last_task) begin
            time_nxt     = '0;
            prev_nxt     = '0;
            done_cnt_nxt = '0;
            scan_idx_nxt = '0;
            state_nxt    = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        if (scan_idx_r == load_cnt_r - pps_pkg::CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + pps_pkg::CNT_W'(1);
        end
      end
      S_DRAIN: begin
        scan_idx_nxt = '0;
        state_nxt    = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sres.found) begin
          time_nxt  = {1'b0, sres.next_arr};
          state_nxt = S_ISSUE;
        end else begin
          if (sres.next_found && (delta < {5'b0, sres.pick_rem})) begin
            run_nxt = delta[pps_pkg::BST_W-1:0];
          end else begin
            run_nxt = sres.pick_rem;
          end
          if (pick_task != prev_r) begin
            state_nxt = S_SWITCH;
          end else begin
            state_nxt = S_UPDATE;
          end
        end
      end
      S_SWITCH: begin
        if (out_free) begin
          push      = 1'b1;
          prev_nxt  = pick_task;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        time_nxt       = time_r + {5'b0, run_r};
        mem_we         = 1'b1;
        mem_wa         = sres.pick_idx;
        mem_wd.arrival = sres.pick_arr;
        mem_wd.burst   = sres.pick_bst;
        mem_wd.remain  = rem_left;
        mem_wd.prio    = sres.pick_pri;
        if (rem_left == '0) begin
          done_cnt_nxt = done_cnt_r + pps_pkg::CNT_W'(1);
          state_nxt    = S_TAT;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_TAT: begin
        tat_nxt   = time_r - {1'b0, sres.pick_arr};
        state_nxt = S_COMP;
      end
      S_COMP: begin
        push_rec.kind = pps_pkg::REC_DONE;
        push_rec.ct   = time_r;
        push_rec.tat  = tat_r;
        push_rec.wt   = tat_r - {5'b0, sres.pick_bst};
        push_rec.fin  = (done_cnt_r == load_cnt_r);
        if (out_free) begin
          push = 1'b1;
          if (done_cnt_r == load_cnt_r) begin
            load_cnt_nxt = '0;
            done_cnt_nxt = '0;
            time_nxt     = '0;
            prev_nxt     = '0;
            state_nxt    = S_LOAD;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      load_cnt_r <= '0;
      done_cnt_r <= '0;
      scan_idx_r <= '0;
      time_r     <= '0;
      prev_r     <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      done_cnt_r <= done_cnt_nxt;
      scan_idx_r <= scan_idx_nxt;
      time_r     <= time_nxt;
      prev_r     <= prev_nxt;
      rd_valid_r <= (state_r == S_ISSUE);
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    tat_r <= tat_nxt;
  end

  pps_outreg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .rec_in    (push_rec),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .rec_out   (out_rec)
  );

  assign out_record_kind     = out_rec.kind;
  assign out_task_number     = out_rec.task_num;
  assign out_completion_time = out_rec.ct;
  assign out_turnaround_time = out_rec.tat;
  assign out_waiting_time    = out_rec.wt;
  assign out_final_record    = out_rec.fin;

endmodule
